// ===== design/nc_pkg.sv =====
package nc_pkg;

    localparam int LFSR_BITS_DEF = 15;
    localparam int CYCLES_W      = 14;
    localparam int PERIOD_W      = 22;
    localparam int COUNT_W       = 23;
    localparam int ACC_W         = COUNT_W + 1;
    localparam int LEN_W         = 7;
    localparam int NARROW_TAP    = 6;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(8);
    localparam logic [COUNT_W-1:0]  TRIG_OFFSET  = COUNT_W'(8);
    localparam logic [LEN_W-1:0]    LEN_FULL     = LEN_W'(64);
    localparam logic [LEN_W-1:0]    LEN_FULL_M1  = LEN_W'(63);
    localparam logic [2:0]          STEP_ENV     = 3'd7;

    typedef enum logic [1:0] {
        FN_ADVANCE = 2'd0,
        FN_SEQ     = 2'd1,
        FN_WRITE   = 2'd2
    } t_func;

    typedef enum logic [1:0] {
        REG_LENGTH   = 2'd0,
        REG_ENVELOPE = 2'd1,
        REG_CLOCK    = 2'd2,
        REG_CONTROL  = 2'd3
    } t_reg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ADV,
        ST_REPORT
    } t_state;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_SUB,
        PH_LOOP
    } t_adv_phase;

    typedef struct packed {
        logic shift;
        logic fill;
    } t_lfsr_cmd;

    typedef struct packed {
        logic start;
        logic load;
    } t_adv_ctl;

    typedef struct packed {
        logic busy;
        logic shift;
        logic done;
    } t_adv_sts;

    function automatic logic [6:0] nc_divisor(input logic [2:0] code);
        logic [6:0] r;
        unique case (code)
            3'd0: r = 7'd8;
            3'd1: r = 7'd16;
            3'd2: r = 7'd32;
            3'd3: r = 7'd48;
            3'd4: r = 7'd64;
            3'd5: r = 7'd80;
            3'd6: r = 7'd96;
            3'd7: r = 7'd112;
        endcase
        return r;
    endfunction

endpackage

// ===== design/noise_channel_lfsr_core.sv =====
// noise sound channel: 15-bit lfsr noise source, frequency countdown,
// length counter and volume envelope
// input channel i_s_axis_*: one item per command; tuser holds the command
// kind (advance cycles, frame sequencer step, register write), tdata holds
// the register select, the write byte and the cycle count
// output channel o_m_axis_*: exactly one result item per input item, giving
// the enable flag, envelope volume, amplitude and noise bit after the command
// sequencing: a non-advance item goes from the accepting edge to the report
// state; an advance item that runs the countdown (channel enabled, nonzero
// count) first passes the countdown engine's subtract step and its loop, which
// makes one lfsr shift per expired frequency period (up to about 2048 shifts),
// since the countdown adder handles one period per cycle; the report state
// loads the result register and the input is ready again from that edge, so
// a new item is only accepted once the previous result is registered
// reset puts all channel state to its power-up values (lfsr all ones,
// channel enabled, period 8); no result is pending after reset
// when the receiver stalls, the finished item waits in the output register
// and the next item is still accepted and worked on; its result then waits
// until the output register is free
module noise_channel_lfsr_core #(
    parameter int LFSR_BITS = nc_pkg::LFSR_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [1:0] reg_select, [9:2] write_data, [23:10] cycles
    input  logic [23:0] i_s_axis_tdata,
    // [1:0] func
    input  logic [1:0]  i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [0] channel_on, [4:1] envelope_level, [8:5] amplitude, [9] noise_bit
    output logic [15:0] o_m_axis_tdata
);

    nc_pkg::t_state                  r_state;
    nc_pkg::t_state                  n_state;

    logic [nc_pkg::PERIOD_W-1:0]     r_period;
    logic [nc_pkg::PERIOD_W-1:0]     n_period;
    logic                            r_narrow;
    logic                            n_narrow;
    logic [nc_pkg::LEN_W-1:0]        r_len;
    logic [nc_pkg::LEN_W-1:0]        n_len;
    logic [3:0]                      r_env_vol;
    logic [3:0]                      n_env_vol;
    logic [2:0]                      r_env_cnt;
    logic [2:0]                      n_env_cnt;
    logic [7:0]                      r_env_set;
    logic [7:0]                      n_env_set;
    logic                            r_cen;
    logic                            n_cen;
    logic                            r_enabled;
    logic                            n_enabled;
    logic [2:0]                      r_step;
    logic [2:0]                      n_step;

    logic                            r_out_valid;
    logic                            n_out_valid;
    logic [15:0]                     r_out_data;
    logic [15:0]                     n_out_data;

    logic                            accept;
    logic                            adv_go;
    nc_pkg::t_func                   func;
    nc_pkg::t_reg                    sel;
    logic [7:0]                      wdata;
    logic [nc_pkg::CYCLES_W-1:0]     cycles;

    nc_pkg::t_lfsr_cmd               lfsr_cmd;
    nc_pkg::t_adv_ctl                adv_ctl;
    nc_pkg::t_adv_sts                adv_sts;
    logic                            noise_bit;
    logic [3:0]                      amp;

    assign func   = nc_pkg::t_func'(i_s_axis_tuser);
    assign sel    = nc_pkg::t_reg'(i_s_axis_tdata[1:0]);
    assign wdata  = i_s_axis_tdata[9:2];
    assign cycles = i_s_axis_tdata[23:10];
    assign accept = i_s_axis_tvalid && o_s_axis_tready;
    assign adv_go = accept && (func == nc_pkg::FN_ADVANCE) && r_enabled
                    && (cycles != '0);

    nc_lfsr #(
        .LFSR_BITS (LFSR_BITS)
    ) u_lfsr (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (lfsr_cmd),
        .i_narrow    (r_narrow),
        .o_noise_bit (noise_bit)
    );

    nc_adv u_adv (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (adv_ctl),
        .i_cycles (cycles),
        .i_period (r_period),
        .o_sts    (adv_sts)
    );

    // command decode and channel register updates
    always_comb begin
        logic even;
        logic [3:0] v;
        n_period       = r_period;
        n_narrow       = r_narrow;
        n_len          = r_len;
        n_env_vol      = r_env_vol;
        n_env_cnt      = r_env_cnt;
        n_env_set      = r_env_set;
        n_cen          = r_cen;
        n_enabled      = r_enabled;
        n_step         = r_step;
        lfsr_cmd.fill  = 1'b0;
        lfsr_cmd.shift = adv_sts.shift;
        adv_ctl.start  = adv_go;
        adv_ctl.load   = 1'b0;
        even           = ~r_step[0];
        v              = r_env_vol;
        if (accept) begin
            unique case (func)
                nc_pkg::FN_SEQ: begin
                    n_step = r_step + 3'd1;
                    if (!n_step[0] && r_cen && (r_len != '0)) begin
                        n_len = r_len - nc_pkg::LEN_W'(1);
                        if (n_len == '0) begin
                            n_enabled = 1'b0;
                        end
                    end
                    if (n_step == nc_pkg::STEP_ENV) begin
                        n_env_cnt = r_env_cnt - 3'd1;
                        if ((n_env_cnt == 3'd0) && (r_env_set[2:0] != 3'd0)) begin
                            if (r_env_set[3] && (r_env_vol != 4'hF)) begin
                                n_env_vol = r_env_vol + 4'd1;
                            end else if (!r_env_set[3] && (r_env_vol != 4'h0)) begin
                                n_env_vol = r_env_vol - 4'd1;
                            end
                            n_env_cnt = r_env_set[2:0];
                        end
                    end
                end
                nc_pkg::FN_WRITE: begin
                    unique case (sel)
                        nc_pkg::REG_LENGTH: begin
                            n_len = nc_pkg::LEN_FULL - nc_pkg::LEN_W'(wdata[5:0]);
                        end
                        nc_pkg::REG_ENVELOPE: begin
                            // volume quirk: adjusted modulo 16 from old and new setting
                            if (wdata[7:3] == 5'd0) begin
                                n_enabled = 1'b0;
                            end
                            if (wdata[3] && (r_env_set[2:0] == 3'd0)) begin
                                v = v + 4'd1;
                            end
                            if (r_env_set[3] ^ wdata[3]) begin
                                if (wdata[3] && (r_env_set[2:0] != 3'd0)) begin
                                    v = v + 4'd2;
                                end
                                v = 4'd0 - v;
                            end
                            if (!wdata[3] && (r_env_set[2:0] == 3'd0)
                                && (wdata[2:0] != 3'd0)) begin
                                v = v - 4'd1;
                            end
                            n_env_vol = v;
                            if ((r_env_set[2:0] == 3'd0) != (wdata[2:0] == 3'd0)) begin
                                n_env_cnt = wdata[2:0];
                            end
                            n_env_set = wdata;
                        end
                        nc_pkg::REG_CLOCK: begin
                            n_period = nc_pkg::PERIOD_W'(nc_pkg::nc_divisor(wdata[2:0]))
                                       << wdata[7:4];
                            n_narrow = wdata[3];
                        end
                        nc_pkg::REG_CONTROL: begin
                            // extra length clock when the counter gets enabled
                            if (wdata[6] && !r_cen && even && (r_len != '0)) begin
                                n_len = r_len - nc_pkg::LEN_W'(1);
                                if (n_len == '0) begin
                                    n_enabled = 1'b0;
                                end
                            end
                            if (wdata[7]) begin
                                n_env_vol     = r_env_set[7:4];
                                n_env_cnt     = r_env_set[2:0];
                                adv_ctl.load  = 1'b1;
                                lfsr_cmd.fill = 1'b1;
                                if (n_len == '0) begin
                                    n_len = (wdata[6] && even) ? nc_pkg::LEN_FULL_M1
                                                                : nc_pkg::LEN_FULL;
                                end
                                if (r_env_set[7:3] != 5'd0) begin
                                    n_enabled = 1'b1;
                                end
                            end
                            n_cen = wdata[6];
                        end
                        default: begin
                        end
                    endcase
                end
                default: begin
                end
            endcase
        end
    end

    assign amp = (r_enabled && noise_bit) ? r_env_vol : 4'd0;

    // item sequencing and output register
    always_comb begin
        n_state         = r_state;
        n_out_valid     = r_out_valid;
        n_out_data      = r_out_data;
        o_s_axis_tready = (r_state == nc_pkg::ST_IDLE);
        if (r_out_valid && i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            nc_pkg::ST_IDLE: begin
                if (adv_go) begin
                    n_state = nc_pkg::ST_ADV;
                end else if (accept) begin
                    n_state = nc_pkg::ST_REPORT;
                end
            end
            nc_pkg::ST_ADV: begin
                if (adv_sts.done) begin
                    n_state = nc_pkg::ST_REPORT;
                end
            end
            nc_pkg::ST_REPORT: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {6'd0, noise_bit, amp, r_env_vol, r_enabled};
                    n_state     = nc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = nc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= nc_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period    <= nc_pkg::PERIOD_RESET;
            r_narrow    <= 1'b0;
            r_len       <= '0;
            r_env_vol   <= '0;
            r_env_cnt   <= '0;
            r_env_set   <= '0;
            r_cen       <= 1'b0;
            r_enabled   <= 1'b1;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_period    <= n_period;
            r_narrow    <= n_narrow;
            r_len       <= n_len;
            r_env_vol   <= n_env_vol;
            r_env_cnt   <= n_env_cnt;
            r_env_set   <= n_env_set;
            r_cen       <= n_cen;
            r_enabled   <= n_enabled;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    a_ready_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_axis_tready |-> !adv_sts.busy)
        else $error("input ready while countdown engine busy");

    a_shift_in_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv_sts.shift |-> (r_state == nc_pkg::ST_ADV))
        else $error("lfsr shift outside an advance item");

    a_adv_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv_go |=> (r_state == nc_pkg::ST_ADV) && adv_sts.busy)
        else $error("advance item did not start the countdown engine");

    a_report_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == nc_pkg::ST_REPORT) && (!r_out_valid || i_m_axis_tready))
        |=> o_m_axis_tvalid && (r_state == nc_pkg::ST_IDLE))
        else $error("finished item not registered at the output");

endmodule

// ===== design/nc_lfsr.sv =====
module nc_lfsr #(
    parameter int LFSR_BITS = nc_pkg::LFSR_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  nc_pkg::t_lfsr_cmd i_cmd,
    input  logic              i_narrow,
    output logic              o_noise_bit
);

    logic [LFSR_BITS-1:0] r_sr;
    logic [LFSR_BITS-1:0] n_sr;
    logic                 r_out_high;
    logic                 n_out_high;
    logic                 fb;

    always_comb begin
        fb         = r_sr[0] ^ r_sr[1];
        n_sr       = r_sr;
        n_out_high = r_out_high;
        if (i_cmd.fill) begin
            n_sr = '1;
        end else if (i_cmd.shift) begin
            n_sr = {fb, r_sr[LFSR_BITS-1:1]};
            if (i_narrow) begin
                n_sr[nc_pkg::NARROW_TAP] = fb;
            end
            n_out_high = ~n_sr[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sr       <= '1;
            r_out_high <= 1'b0;
        end else begin
            r_sr       <= n_sr;
            r_out_high <= n_out_high;
        end
    end

    assign o_noise_bit = r_out_high;

endmodule

// ===== design/nc_adv.sv =====
module nc_adv (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  nc_pkg::t_adv_ctl              i_ctl,
    input  logic [nc_pkg::CYCLES_W-1:0]   i_cycles,
    input  logic [nc_pkg::PERIOD_W-1:0]   i_period,
    output nc_pkg::t_adv_sts              o_sts
);

    nc_pkg::t_adv_phase              r_phase;
    nc_pkg::t_adv_phase              n_phase;
    logic [nc_pkg::COUNT_W-1:0]      r_cnt;
    logic [nc_pkg::COUNT_W-1:0]      n_cnt;
    logic [nc_pkg::ACC_W-1:0]        r_acc;
    logic [nc_pkg::ACC_W-1:0]        n_acc;
    logic [nc_pkg::CYCLES_W-1:0]     r_cyc;
    logic [nc_pkg::CYCLES_W-1:0]     n_cyc;
    logic [nc_pkg::ACC_W-1:0]        addend;
    logic [nc_pkg::ACC_W-1:0]        sum;
    logic                            acc_le_zero;

    // one shared adder: subtract the elapsed count, then add periods back
    always_comb begin
        if (r_phase == nc_pkg::PH_SUB) begin
            addend = nc_pkg::ACC_W'(0) - nc_pkg::ACC_W'(r_cyc);
        end else begin
            addend = nc_pkg::ACC_W'(i_period);
        end
        sum         = r_acc + addend;
        acc_le_zero = r_acc[nc_pkg::ACC_W-1] || (r_acc == '0);
    end

    always_comb begin
        n_phase     = r_phase;
        n_cnt       = r_cnt;
        n_acc       = r_acc;
        n_cyc       = r_cyc;
        o_sts.busy  = (r_phase != nc_pkg::PH_IDLE);
        o_sts.shift = 1'b0;
        o_sts.done  = 1'b0;
        unique case (r_phase)
            nc_pkg::PH_IDLE: begin
                if (i_ctl.start) begin
                    n_acc   = {1'b0, r_cnt};
                    n_cyc   = i_cycles;
                    n_phase = nc_pkg::PH_SUB;
                end
                if (i_ctl.load) begin
                    n_cnt = nc_pkg::COUNT_W'(i_period >> 1) + nc_pkg::TRIG_OFFSET;
                end
            end
            nc_pkg::PH_SUB: begin
                n_acc   = sum;
                n_phase = nc_pkg::PH_LOOP;
            end
            nc_pkg::PH_LOOP: begin
                if (acc_le_zero) begin
                    n_acc       = sum;
                    o_sts.shift = 1'b1;
                end else begin
                    n_cnt      = r_acc[nc_pkg::COUNT_W-1:0];
                    o_sts.done = 1'b1;
                    n_phase    = nc_pkg::PH_IDLE;
                end
            end
            default: begin
                n_phase = nc_pkg::PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= nc_pkg::PH_IDLE;
            r_cnt   <= '0;
        end else begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        r_cyc <= n_cyc;
    end

endmodule

// ===== tb/noise_channel_lfsr_core_tb.sv =====
module noise_channel_lfsr_core_tb;

    localparam int          LW             = nc_pkg::LFSR_BITS_DEF;
    localparam logic [1:0]  FN_UNUSED      = 2'd3;
    localparam int          WATCHDOG_LIMIT = 20000;
    localparam int          DRAIN_CYCLES   = 20;
    localparam int unsigned DIV_TABLE [8]  = '{8, 16, 32, 48, 64, 80, 96, 112};

    typedef struct {
        logic       on;
        logic [3:0] level;
        logic [3:0] amp;
        logic       noise;
    } t_chan_out;

    logic        i_clk;
    logic        i_rst_n         = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    // [1:0] reg_select, [9:2] write_data, [23:10] cycles
    logic [23:0] i_s_axis_tdata  = '0;
    // [1:0] func
    logic [1:0]  i_s_axis_tuser  = '0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    // [0] channel_on, [4:1] envelope_level, [8:5] amplitude, [9] noise_bit
    logic [15:0] o_m_axis_tdata;

    // channel state mirror
    logic [LW-1:0]               lfsr;
    logic [nc_pkg::COUNT_W-1:0]  freq_cnt;
    logic [nc_pkg::PERIOD_W-1:0] freq_period;
    logic                        narrow;
    logic [nc_pkg::LEN_W-1:0]    len_left;
    logic [3:0]                  env_vol;
    logic [2:0]                  env_cnt;
    logic [7:0]                  env_set;
    logic                        ctr_en;
    logic                        chan_en;
    logic                        out_hi;
    logic [2:0]                  seq_step;

    t_chan_out expected_outputs[$];
    int        mismatches  = 0;
    int        results_seen = 0;
    int        quiet_cycles = 0;
    bit        idle_on      = 1'b0;
    int        rx_stall     = 0;

    noise_channel_lfsr_core DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void reset_channel();
        lfsr        = '1;
        freq_cnt    = '0;
        freq_period = nc_pkg::PERIOD_W'(8);
        narrow      = 1'b0;
        len_left    = '0;
        env_vol     = '0;
        env_cnt     = '0;
        env_set     = '0;
        ctr_en      = 1'b0;
        chan_en     = 1'b1;
        out_hi      = 1'b0;
        seq_step    = '0;
    endfunction

    function automatic void clock_length();
        if (len_left != 0) begin
            len_left = len_left - nc_pkg::LEN_W'(1);
            if (len_left == 0)
                chan_en = 1'b0;
        end
    endfunction

    function automatic t_chan_out apply_channel_item(input logic [1:0] fn,
                                                     input logic [1:0] sel,
                                                     input logic [7:0] d,
                                                     input logic [13:0] cyc);
        longint      t;
        logic        fb;
        int unsigned v;
        logic [7:0]  old;
        logic        even;
        t_chan_out   r;
        case (fn)
            nc_pkg::FN_ADVANCE: begin
                if (chan_en && cyc != 0) begin
                    t = longint'(freq_cnt) - longint'(cyc);
                    while (t <= 0) begin
                        t += longint'(freq_period);
                        fb = lfsr[0] ^ lfsr[1];
                        lfsr = {fb, lfsr[LW-1:1]};
                        if (narrow)
                            lfsr[nc_pkg::NARROW_TAP] = fb;
                        out_hi = ~lfsr[0];
                    end
                    freq_cnt = nc_pkg::COUNT_W'(t);
                end
            end
            nc_pkg::FN_SEQ: begin
                seq_step = seq_step + 3'd1;
                if (!seq_step[0] && ctr_en)
                    clock_length();
                if (seq_step == 3'd7) begin
                    env_cnt = env_cnt - 3'd1;
                    if (env_cnt == 0 && env_set[2:0] != 0) begin
                        if (env_set[3] && env_vol < 15)
                            env_vol = env_vol + 4'd1;
                        else if (!env_set[3] && env_vol > 0)
                            env_vol = env_vol - 4'd1;
                        env_cnt = env_set[2:0];
                    end
                end
            end
            nc_pkg::FN_WRITE: begin
                case (sel)
                    nc_pkg::REG_LENGTH: begin
                        len_left = nc_pkg::LEN_W'(64 - int'(d[5:0]));
                    end
                    nc_pkg::REG_ENVELOPE: begin
                        // volume update follows the hardware write quirk, mod 16
                        old = env_set;
                        v = env_vol;
                        if (d[7:3] == 0)
                            chan_en = 1'b0;
                        if (d[3] && old[2:0] == 0)
                            v += 1;
                        if (old[3] ^ d[3]) begin
                            if (d[3] && old[2:0] != 0)
                                v += 2;
                            v = 16 - v;
                        end
                        if (!d[3] && old[2:0] == 0 && d[2:0] != 0)
                            v -= 1;
                        env_vol = v[3:0];
                        if ((old[2:0] == 0) != (d[2:0] == 0))
                            env_cnt = d[2:0];
                        env_set = d;
                    end
                    nc_pkg::REG_CLOCK: begin
                        freq_period = nc_pkg::PERIOD_W'(DIV_TABLE[d[2:0]] << d[7:4]);
                        narrow = d[3];
                    end
                    default: begin
                        even = ~seq_step[0];
                        // extra length clock when the counter turns on
                        if (d[6] && !ctr_en && even)
                            clock_length();
                        if (d[7]) begin
                            env_vol  = env_set[7:4];
                            env_cnt  = env_set[2:0];
                            freq_cnt = nc_pkg::COUNT_W'(freq_period / 2 + 8);
                            lfsr     = '1;
                            if (len_left == 0)
                                len_left = (d[6] && even) ? nc_pkg::LEN_W'(63)
                                                          : nc_pkg::LEN_W'(64);
                            if (env_set[7:3] != 0)
                                chan_en = 1'b1;
                        end
                        ctr_en = d[6];
                    end
                endcase
            end
            default: ;
        endcase
        r.on    = chan_en;
        r.level = env_vol;
        r.amp   = (chan_en && out_hi) ? env_vol : 4'd0;
        r.noise = out_hi;
        return r;
    endfunction

    task automatic send_item(input logic [1:0] fn, input logic [1:0] sel,
                             input logic [7:0] d, input logic [13:0] cyc);
        if (idle_on && $urandom_range(0, 7) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= fn;
        i_s_axis_tdata  <= {cyc, d, sel};
        do @(posedge i_clk); while (!o_s_axis_tready);
        expected_outputs.push_back(apply_channel_item(fn, sel, d, cyc));
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_chan_out got;
        t_chan_out want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.on    = o_m_axis_tdata[0];
            got.level = o_m_axis_tdata[4:1];
            got.amp   = o_m_axis_tdata[8:5];
            got.noise = o_m_axis_tdata[9];
            if (expected_outputs.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d: unexpected item tdata=%h", results_seen,
                             o_m_axis_tdata);
            end else begin
                want = expected_outputs.pop_front();
                if (got.on !== want.on || got.level !== want.level ||
                    got.amp !== want.amp || got.noise !== want.noise) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d: on/level/amp/noise exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                                 results_seen,
                                 want.on, want.level, want.amp, want.noise,
                                 got.on, got.level, got.amp, got.noise);
                end
            end
            results_seen++;
        end
    end

    // receiver stalls
    always @(posedge i_clk) begin
        if (rx_stall != 0) begin
            rx_stall <= rx_stall - 1;
            i_m_axis_tready <= (rx_stall == 1);
        end else if (idle_on && $urandom_range(0, 11) == 0) begin
            rx_stall <= $urandom_range(1, 14);
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic test_reset_state();
        send_item(nc_pkg::FN_ADVANCE, nc_pkg::REG_LENGTH, 8'h00, 14'd0);
        send_item(FN_UNUSED, nc_pkg::REG_CONTROL, 8'hFF, 14'h3FFF);
    endtask

    task automatic test_register_ops();
        send_item(nc_pkg::FN_WRITE, nc_pkg::REG_ENVELOPE, 8'hF1, 14'd0);
        send_item(nc_pkg::FN_WRITE, nc_pkg::REG_CLOCK, 8'h00, 14'd0);
        send_item(nc_pkg::FN_WRITE, nc_pkg::REG_CONTROL, 8'hC0, 14'd0);
        send_item(nc_pkg::FN_ADVANCE, nc_pkg::REG_LENGTH, 8'h00, 14'h3FFF);
        send_item(nc_pkg::FN_WRITE, nc_pkg::REG_CLOCK, 8'hFF, 14'd0);
        send_item(nc_pkg::FN_ADVANCE, nc_pkg::REG_LENGTH, 8'h00, 14'd1);
        send_item(nc_pkg::FN_WRITE, nc_pkg::REG_CLOCK, 8'h0B, 14'd0);
        send_item(nc_pkg::FN_ADVANCE, nc_pkg::REG_LENGTH, 8'h00, 14'd8192);
        send_item(nc_pkg::FN_WRITE, nc_pkg::REG_LENGTH, 8'h3F, 14'd0);
        send_item(nc_pkg::FN_WRITE, nc_pkg::REG_LENGTH, 8'h00, 14'd0);
        send_item(nc_pkg::FN_WRITE, nc_pkg::REG_CONTROL, 8'h80, 14'd0);
    endtask

    task automatic test_special_cases();
        // dac off, then advance while disabled
        send_item(nc_pkg::FN_WRITE, nc_pkg::REG_ENVELOPE, 8'h07, 14'd0);
        send_item(nc_pkg::FN_ADVANCE, nc_pkg::REG_LENGTH, 8'h00, 14'd500);
        // envelope write quirk, period going to zero
        send_item(nc_pkg::FN_WRITE, nc_pkg::REG_ENVELOPE, 8'hF8, 14'd0);
        send_item(nc_pkg::FN_WRITE, nc_pkg::REG_CONTROL, 8'h80, 14'd0);
        // envelope countdown wraps on step 7
        repeat (7) send_item(nc_pkg::FN_SEQ, nc_pkg::REG_LENGTH, 8'h00, 14'd0);
        // counter enable on an odd step
        send_item(nc_pkg::FN_WRITE, nc_pkg::REG_CONTROL, 8'h40, 14'd0);
    endtask

    task automatic test_random_traffic(input int n, input bit paced);
        int          r;
        logic [1:0]  fn;
        logic [1:0]  sel;
        logic [7:0]  d;
        logic [13:0] cyc;
        for (int i = 0; i < n; i++) begin
            if (!paced)
                idle_on = 1'b0;
            else if (i % 60 == 0)
                idle_on = ($urandom_range(0, 3) != 0);
            r   = int'($urandom_range(0, 99));
            sel = 2'($urandom_range(0, 3));
            d   = 8'($urandom_range(0, 255));
            cyc = 14'($urandom_range(0, 16383));
            if (r < 40) begin
                fn = nc_pkg::FN_ADVANCE;
                if ($urandom_range(0, 6) != 0)
                    cyc = 14'($urandom_range(0, 600));
            end else if (r < 66) begin
                fn = nc_pkg::FN_SEQ;
            end else if (r < 70) begin
                fn = FN_UNUSED;
            end else begin
                fn = nc_pkg::FN_WRITE;
                case (sel)
                    nc_pkg::REG_ENVELOPE: begin
                        if (d[7:3] == 0 && $urandom_range(0, 4) != 0)
                            d[7:4] = 4'($urandom_range(1, 15));
                    end
                    nc_pkg::REG_CLOCK: begin
                        if ($urandom_range(0, 4) != 0)
                            d[7:4] = 4'($urandom_range(0, 3));
                    end
                    nc_pkg::REG_CONTROL: begin
                        d[7] = ($urandom_range(0, 2) != 0);
                    end
                    default: ;
                endcase
            end
            send_item(fn, sel, d, cyc);
        end
    endtask

    initial begin
        reset_channel();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        idle_on = 1'b1;
        test_reset_state();
        test_register_ops();
        test_special_cases();
        test_random_traffic(680, 1'b1);
        test_random_traffic(70, 1'b0);
        i_s_axis_tvalid <= 1'b0;
        while (expected_outputs.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
